FILE: rtl/mrrt_pkg.sv
package mrrt_pkg;

	// Table geometry.
	localparam int TABLE_ENTRIES = 16;
	localparam int COUNT_BITS    = 16;
	localparam int ADDR_BITS     = 48;
	localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// Widths of the result ports.
	localparam int STATUS_BITS   = 3;
	localparam int OUT_IDX_BITS  = 4;
	localparam int OUT_CNT_BITS  = 16;

	// Request kinds.
	localparam logic REQ_ADD     = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_BITS-1:0] {
		ST_NEW     = 3'd0,
		ST_RAISED  = 3'd1,
		ST_LOWERED = 3'd2,
		ST_FREED   = 3'd3,
		ST_MISS    = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_DECIDE
	} state_t;

	// One table entry as held in the memory.
	typedef struct packed {
		logic [ADDR_BITS-1:0]  lower;
		logic [ADDR_BITS-1:0]  upper;
		logic [COUNT_BITS-1:0] count;
	} entry_t;

endpackage

FILE: rtl/multicast_range_refcount_table.sv
// Reference-counted multicast address range table. A request is taken when
// start is high and busy is low; busy then stays high while the block scans
// its entry memory one slot per cycle, and exactly one result appears on
// status, entry_index and use_count with done high for a single cycle, which
// the receiver must take since it cannot stall. The scan walks through the
// entry memory over its single read port, and a new request may be accepted
// in the cycle that shows the result. The table is empty right after reset
// and needs no clearing pass.
module multicast_range_refcount_table import mrrt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     req_type,
	input  logic                     single_address,
	input  logic [ADDR_BITS-1:0]     lower_addr,
	input  logic [ADDR_BITS-1:0]     upper_addr,
	output logic                     done,
	output logic [STATUS_BITS-1:0]   status,
	output logic [OUT_IDX_BITS-1:0]  entry_index,
	output logic [OUT_CNT_BITS-1:0]  use_count
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(TABLE_ENTRIES - 1);

	state_t state_q, state_d;

	// Latched request.
	logic                  rel_q;
	logic [ADDR_BITS-1:0]  lo_q;
	logic [ADDR_BITS-1:0]  hi_q;

	// Scan address and compare stage.
	logic [IDX_BITS-1:0]   scan_idx_q;
	logic                  cmp_vld_s1;
	logic [IDX_BITS-1:0]   cmp_idx_s1;
	entry_t                rd_s1;

	// Search results.
	logic                  hit_found_q;
	logic [IDX_BITS-1:0]   hit_idx_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic                  free_found_q;
	logic [IDX_BITS-1:0]   free_idx_q;

	// Entry memory and valid bits.
	entry_t                mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	// Decision outputs.
	logic                  accept;
	logic                  cmp_match;
	logic                  mem_we;
	logic [IDX_BITS-1:0]   tgt_idx;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  set_valid;
	logic                  clr_valid;
	status_t               res_status;
	logic                  res_has_slot;
	logic [IDX_BITS+OUT_IDX_BITS-1:0]   idx_ext;
	logic [COUNT_BITS+OUT_CNT_BITS-1:0] cnt_ext;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Entry read at the compare stage matches the request range.
	assign cmp_match = valid_q[cmp_idx_s1] && (rd_s1.lower == lo_q) && (rd_s1.upper == hi_q);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_idx_q == LAST_IDX) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL:   state_d = S_DECIDE;
			S_DECIDE: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request latch.
	always_ff @(posedge clk) begin
		if (accept) begin
			rel_q <= req_type;
			lo_q  <= lower_addr;
			hi_q  <= single_address ? lower_addr : upper_addr;
		end
	end

	// Scan address counter and compare stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_vld_s1 <= (state_q == S_SCAN);
			cmp_idx_s1 <= scan_idx_q;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (state_q == S_SCAN && scan_idx_q != LAST_IDX) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	// First hit and lowest free slot, gathered as the scan goes by.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (accept) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (cmp_match && !hit_found_q) begin
				hit_found_q <= 1'b1;
			end
			if (!valid_q[cmp_idx_s1] && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (cmp_match && !hit_found_q) begin
				hit_idx_q <= cmp_idx_s1;
				hit_cnt_q <= rd_s1.count;
			end
			if (!valid_q[cmp_idx_s1] && !free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	// Decision: new count, write-back and result code.
	always_comb begin
		mem_we       = 1'b0;
		tgt_idx      = hit_idx_q;
		new_cnt      = hit_cnt_q;
		set_valid    = 1'b0;
		clr_valid    = 1'b0;
		res_status   = ST_MISS;
		res_has_slot = 1'b0;
		if (state_q == S_DECIDE) begin
			if (rel_q == REQ_ADD) begin
				if (hit_found_q) begin
					if (hit_cnt_q != COUNT_MAX) begin
						new_cnt = hit_cnt_q + 1'b1;
					end
					mem_we       = 1'b1;
					res_status   = ST_RAISED;
					res_has_slot = 1'b1;
				end else if (free_found_q) begin
					tgt_idx      = free_idx_q;
					new_cnt      = COUNT_BITS'(1);
					mem_we       = 1'b1;
					set_valid    = 1'b1;
					res_status   = ST_NEW;
					res_has_slot = 1'b1;
				end else begin
					res_status   = ST_FULL;
				end
			end else begin
				if (hit_found_q) begin
					if (hit_cnt_q != '0) begin
						new_cnt = hit_cnt_q - 1'b1;
					end
					mem_we       = 1'b1;
					res_has_slot = 1'b1;
					if (new_cnt == '0) begin
						clr_valid  = 1'b1;
						res_status = ST_FREED;
					end else begin
						res_status = ST_LOWERED;
					end
				end else begin
					res_status = ST_MISS;
				end
			end
		end
	end

	// Entry memory: one read port for the scan, one write port for write-back.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tgt_idx] <= '{lower: lo_q, upper: hi_q, count: new_cnt};
		end
		rd_s1 <= mem[scan_idx_q];
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (set_valid) begin
			valid_q[tgt_idx] <= 1'b1;
		end else if (clr_valid) begin
			valid_q[tgt_idx] <= 1'b0;
		end
	end

	// Result registers; slot and count are cut or padded to the port widths.
	assign idx_ext = {{OUT_IDX_BITS{1'b0}}, tgt_idx};
	assign cnt_ext = {{OUT_CNT_BITS{1'b0}}, new_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == S_DECIDE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) begin
			status      <= res_status;
			entry_index <= res_has_slot ? idx_ext[OUT_IDX_BITS-1:0] : '0;
			use_count   <= (res_has_slot && res_status != ST_FREED) ?
				cnt_ext[OUT_CNT_BITS-1:0] : '0;
		end
	end

endmodule

FILE: rtl/mrrt_checker.sv
module mrrt_checker import mrrt_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [STATUS_BITS-1:0]  status,
	input logic [OUT_IDX_BITS-1:0] entry_index,
	input logic [OUT_CNT_BITS-1:0] use_count
);

	// An accepted request keeps the block busy and gives no result at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("request accepted but block not busy");

	// A result shows exactly when the block has just finished a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $fell(busy))
		else $error("result without a finished request");

	// The result strobe lasts one cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// Miss and full touch no slot and carry no count.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_MISS || status == ST_FULL) |->
			entry_index == '0 && use_count == '0)
		else $error("miss or full result carries slot or count");

	// A new entry always starts with a count of one.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NEW |-> use_count == OUT_CNT_BITS'(1))
		else $error("new entry with count other than one");

endmodule

bind multicast_range_refcount_table mrrt_checker u_mrrt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.entry_index (entry_index),
	.use_count   (use_count)
);
